// File: rtl/bsl_pkg.sv
package bsl_pkg;

    localparam int POS_WIDTH   = 20;
    localparam int KIND_WIDTH  = 6;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_WIDTH   = $clog2(MAX_RESULTS + 1);

    typedef logic [POS_WIDTH-1:0]  pos_t;
    typedef logic [KIND_WIDTH-1:0] kind_t;
    typedef logic [CNT_WIDTH-1:0]  cnt_t;

    localparam pos_t POS_MAX  = '1;
    localparam pos_t POS_ZERO = '0;
    localparam pos_t POS_ONE  = POS_WIDTH'(1);

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_BLANK   = 3'd1,
        CLS_KEYWORD = 3'd2,
        CLS_IDENT   = 3'd3,
        CLS_PARAM   = 3'd4,
        CLS_NUMBER  = 3'd5
    } run_class_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_ZERO_BYTE   = 2'd1,
        ERR_UNHANDLED   = 2'd2,
        ERR_PARAM_DIGIT = 2'd3
    } err_t;

    localparam kind_t KIND_NEWLINE = 6'd0;
    localparam kind_t KIND_END     = 6'd35;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        kind_t kind;
        pos_t  pos;
        pos_t  line;
        pos_t  col;
        pos_t  len;
        err_t  err;
        logic  last;
    } res_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_UNDER);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic in_run_class(input run_class_t cls, input logic [7:0] c);
        logic r;
        unique case (cls)
            CLS_BLANK:                         r = is_blank(c);
            CLS_NUMBER:                        r = is_digit(c);
            CLS_KEYWORD, CLS_IDENT, CLS_PARAM: r = is_word(c);
            default:                           r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic punct_t punct_lookup(input logic [7:0] c);
        punct_t p;
        p.hit = 1'b1;
        unique case (c)
            "(":     p.kind = 6'd6;
            ")":     p.kind = 6'd7;
            "{":     p.kind = 6'd8;
            "}":     p.kind = 6'd9;
            "[":     p.kind = 6'd10;
            "]":     p.kind = 6'd11;
            "<":     p.kind = 6'd12;
            ">":     p.kind = 6'd13;
            ",":     p.kind = 6'd14;
            ".":     p.kind = 6'd15;
            ";":     p.kind = 6'd16;
            ":":     p.kind = 6'd17;
            "!":     p.kind = 6'd18;
            "#":     p.kind = 6'd19;
            "%":     p.kind = 6'd20;
            "^":     p.kind = 6'd21;
            "&":     p.kind = 6'd22;
            "*":     p.kind = 6'd23;
            "-":     p.kind = 6'd24;
            "=":     p.kind = 6'd25;
            "+":     p.kind = 6'd26;
            "/":     p.kind = 6'd27;
            8'h5C:   p.kind = 6'd28;
            "?":     p.kind = 6'd29;
            "|":     p.kind = 6'd30;
            8'h27:   p.kind = 6'd31;
            8'h22:   p.kind = 6'd32;
            8'h60:   p.kind = 6'd33;
            "~":     p.kind = 6'd34;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = KIND_NEWLINE;
            end
        endcase
        return p;
    endfunction

endpackage

// File: rtl/byte_stream_lexer.sv
// Byte stream lexer.
// Slave channel: one source byte per beat. s_tdata holds the byte, s_tuser[0]
// marks it present (0 lets an empty beat close the stream), s_tlast closes the
// stream: the open run is flushed and an end token follows.
// Master channel: one token record per beat. s_tdata-side fields are decoded
// in the same cycle a byte is accepted, so the first record of a byte is on
// m_tdata in the cycle after acceptance. A byte gives zero to three records;
// m_tlast marks the last record of each byte.
// Throughput: one byte per cycle while each byte yields at most one record and
// m_tready is high; a byte with more records stalls s_tready. The decode path
// is a single pass of character compares and saturating counter increments.
// A three-entry result queue parts the two sides; s_tready is high when the
// queue is empty or its final entry is taken in the same cycle.
// Errors (zero byte, unhandled character, '$' then digit) are sticky: every
// later beat returns one error record until reset.
// Reset clears the run state, counters (line and column start at 1), the
// error flag and the result queue. A stalled receiver holds m_tdata steady
// and back-pressures s_tready once the queue cannot drain.
module byte_stream_lexer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // text_byte
    input  logic [0:0]                     s_tuser,   // byte_present
    input  logic                           s_tlast,   // end_of_text
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [4*bsl_pkg::POS_WIDTH-1:0] m_tdata,  // start_pos, line_no, column_no, token_len
    output logic [7:0]                     m_tuser,   // lex_kind, error_code
    output logic                           m_tlast    // last_result
);
    import bsl_pkg::*;

    run_class_t class_reg, class_next;
    pos_t       start_pos_reg, start_pos_next;
    pos_t       start_line_reg, start_line_next;
    pos_t       start_col_reg, start_col_next;
    pos_t       byte_pos_reg, byte_pos_next;
    pos_t       line_reg, line_next;
    pos_t       col_reg, col_next;
    logic       pf_reg, pf_next;
    logic       halted_reg, halted_next;
    err_t       err_kind_reg, err_kind_next;

    res_t       q_reg [0:MAX_RESULTS-1];
    cnt_t       cnt_reg;

    res_t       r [0:MAX_RESULTS-1];
    cnt_t       n;

    logic       in_fire;
    logic       out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == CNT_WIDTH'(1)) && m_tready);

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {q_reg[0].len, q_reg[0].col, q_reg[0].line, q_reg[0].pos};
    assign m_tuser  = {q_reg[0].err, q_reg[0].kind};
    assign m_tlast  = q_reg[0].last;

    always_comb
    begin
        logic [7:0] c;
        logic       present;
        logic       taken;
        logic       err_hit;
        err_t       err_val;
        punct_t     pc;

        c               = s_tdata;
        present         = s_tuser[0];
        taken           = 1'b0;
        err_hit         = 1'b0;
        err_val         = ERR_NONE;
        pc              = punct_lookup(c);
        class_next      = class_reg;
        start_pos_next  = start_pos_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        byte_pos_next   = byte_pos_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        pf_next         = pf_reg;
        halted_next     = halted_reg;
        err_kind_next   = err_kind_reg;
        n               = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            r[i] = '0;
        end

        if (halted_reg)
        begin
            r[0].err  = err_kind_reg;
            r[0].last = 1'b1;
            n         = CNT_WIDTH'(1);
        end
        else
        begin
            if (present)
            begin
                if ((class_reg == CLS_PARAM) && pf_reg)
                begin
                    pf_next = 1'b0;
                    if (is_digit(c))
                    begin
                        err_hit = 1'b1;
                        err_val = ERR_PARAM_DIGIT;
                    end
                end
                if (!err_hit)
                begin
                    if (class_reg != CLS_NONE)
                    begin
                        if (in_run_class(class_reg, c))
                        begin
                            taken = 1'b1;
                        end
                        else
                        begin
                            r[n].kind  = KIND_WIDTH'(class_reg);
                            r[n].pos   = start_pos_reg;
                            r[n].line  = start_line_reg;
                            r[n].col   = start_col_reg;
                            r[n].len   = byte_pos_reg - start_pos_reg;
                            n          = n + CNT_WIDTH'(1);
                            class_next = CLS_NONE;
                            pf_next    = 1'b0;
                        end
                    end
                    if (!taken)
                    begin
                        start_pos_next  = byte_pos_reg;
                        start_line_next = line_reg;
                        start_col_next  = col_reg;
                        priority if (c == CH_NL)
                        begin
                            r[n].kind = KIND_NEWLINE;
                            r[n].pos  = byte_pos_reg;
                            r[n].line = line_reg;
                            r[n].col  = col_reg;
                            r[n].len  = POS_ONE;
                            n         = n + CNT_WIDTH'(1);
                        end
                        else if (is_blank(c))
                            class_next = CLS_BLANK;
                        else if (c == CH_AT)
                            class_next = CLS_KEYWORD;
                        else if (is_alpha(c))
                            class_next = CLS_IDENT;
                        else if (c == CH_DOLLAR)
                        begin
                            class_next = CLS_PARAM;
                            pf_next    = 1'b1;
                        end
                        else if (is_digit(c))
                            class_next = CLS_NUMBER;
                        else if (c == CH_NUL)
                        begin
                            err_hit = 1'b1;
                            err_val = ERR_ZERO_BYTE;
                        end
                        else if (pc.hit)
                        begin
                            r[n].kind = pc.kind;
                            r[n].pos  = byte_pos_reg;
                            r[n].line = line_reg;
                            r[n].col  = col_reg;
                            r[n].len  = POS_ONE;
                            n         = n + CNT_WIDTH'(1);
                        end
                        else
                        begin
                            err_hit = 1'b1;
                            err_val = ERR_UNHANDLED;
                        end
                        if (class_next == CLS_NONE)
                        begin
                            start_pos_next  = start_pos_reg;
                            start_line_next = start_line_reg;
                            start_col_next  = start_col_reg;
                        end
                    end
                    if (!err_hit)
                    begin
                        if (c == CH_NL)
                        begin
                            line_next = sat_inc(line_reg);
                            col_next  = POS_ONE;
                        end
                        else
                        begin
                            col_next = sat_inc(col_reg);
                        end
                        byte_pos_next = sat_inc(byte_pos_reg);
                    end
                end
            end

            if (err_hit)
            begin
                halted_next     = 1'b1;
                err_kind_next   = err_val;
                class_next      = CLS_NONE;
                pf_next         = 1'b0;
                start_pos_next  = start_pos_reg;
                start_line_next = start_line_reg;
                start_col_next  = start_col_reg;
                byte_pos_next   = byte_pos_reg;
                line_next       = line_reg;
                col_next        = col_reg;
                r[n].err        = err_val;
                n               = n + CNT_WIDTH'(1);
            end
            else if (s_tlast)
            begin
                if (class_next != CLS_NONE)
                begin
                    r[n].kind = KIND_WIDTH'(class_next);
                    r[n].pos  = start_pos_next;
                    r[n].line = start_line_next;
                    r[n].col  = start_col_next;
                    r[n].len  = byte_pos_next - start_pos_next;
                    n         = n + CNT_WIDTH'(1);
                end
                class_next    = CLS_NONE;
                pf_next       = 1'b0;
                r[n].kind     = KIND_END;
                r[n].len      = POS_ONE;
                n             = n + CNT_WIDTH'(1);
                byte_pos_next = POS_ZERO;
                line_next     = POS_ONE;
                col_next      = POS_ONE;
            end

            if (n != '0)
            begin
                r[n - CNT_WIDTH'(1)].last = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg      <= CLS_NONE;
            start_pos_reg  <= POS_ZERO;
            start_line_reg <= POS_ZERO;
            start_col_reg  <= POS_ZERO;
            byte_pos_reg   <= POS_ZERO;
            line_reg       <= POS_ONE;
            col_reg        <= POS_ONE;
            pf_reg         <= 1'b0;
            halted_reg     <= 1'b0;
            err_kind_reg   <= ERR_NONE;
        end
        else if (in_fire)
        begin
            class_reg      <= class_next;
            start_pos_reg  <= start_pos_next;
            start_line_reg <= start_line_next;
            start_col_reg  <= start_col_next;
            byte_pos_reg   <= byte_pos_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            pf_reg         <= pf_next;
            halted_reg     <= halted_next;
            err_kind_reg   <= err_kind_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (in_fire)
        begin
            cnt_reg <= n;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - CNT_WIDTH'(1);
        end
    end

    // load a fresh batch, or advance the queue by one beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                q_reg[i] <= r[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (cnt_reg == '0) || ((cnt_reg == CNT_WIDTH'(1)) && out_fire))
        else $error("byte accepted while queue busy");

    a_halt_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && halted_reg) |=> (cnt_reg == CNT_WIDTH'(1)) && q_reg[0].last
            && (q_reg[0].err != ERR_NONE))
        else $error("halted step did not give one error record");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (q_reg[0].err != ERR_NONE)) |-> m_tlast)
        else $error("error record not last of its step");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (q_reg[0].kind == KIND_END)) |-> m_tlast && (q_reg[0].pos == POS_ZERO))
        else $error("end token malformed");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import bsl_pkg::*;

    localparam int P          = POS_WIDTH;
    localparam int PUNCT_BASE = 6;
    localparam int PUNCT_NUM  = 29;

    typedef struct {
        logic [7:0] ch;
        logic       present;
        logic       fin;
        int         gap;
        bit         hold;
    } item_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             s_tlast = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [4*P-1:0]   m_tdata;   // start_pos, line_no, column_no, token_len
    logic [7:0]       m_tuser;   // lex_kind, error_code
    logic             m_tlast;   // last_result

    byte_stream_lexer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    item_t      byte_q[$];
    res_t       token_q[$];
    item_t      nxt;
    res_t       got;
    res_t       want;
    int         fail_cnt = 0;
    int         tx_gap;
    int         rx_wait;
    int         rx_count;
    int         rx_draw;
    int         choke;
    bit         choked;
    logic       rx_calm;
    bit         calm = 0;
    bit         hold_next = 0;
    int         guard;
    int         stream_idx;
    int         err_pick;
    int         j;
    string      punct_set = "(){}[]<>,.;:!#%^&*-=+/\\?|'\"`~";

    // lexer state mirror
    run_class_t cls;
    pos_t       rs_pos;
    pos_t       rs_line;
    pos_t       rs_col;
    pos_t       at_pos;
    pos_t       at_line;
    pos_t       at_col;
    logic       par_pending;
    logic       stopped;
    err_t       stop_code;

    assign rx_calm = (rx_count >= 150) && (rx_count < 200);

    task automatic report(input string what);
        $display("MISMATCH: %s", what);
        fail_cnt++;
    endtask

    function automatic pos_t bump(input pos_t v);
        return (v == {P{1'b1}}) ? v : v + POS_ONE;
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit stays_in_run(input run_class_t k, input logic [7:0] c);
        case (k)
            CLS_BLANK:                         return blank_ch(c);
            CLS_NUMBER:                        return digit_ch(c);
            CLS_KEYWORD, CLS_IDENT, CLS_PARAM: return letter_ch(c) || digit_ch(c);
            default:                           return 1'b0;
        endcase
    endfunction

    function automatic int punct_index(input logic [7:0] c);
        int i;
        for (i = 0; i < PUNCT_NUM; i++)
            if (punct_set[i] == c)
                return i;
        return -1;
    endfunction

    task automatic push_tok(input kind_t k, input pos_t p, input pos_t l, input pos_t c,
                            input pos_t n, input err_t e, input logic lst);
        res_t r;
        r.kind = k;
        r.pos  = p;
        r.line = l;
        r.col  = c;
        r.len  = n;
        r.err  = e;
        r.last = lst;
        token_q.push_back(r);
    endtask

    task automatic open_run(input run_class_t k);
        cls     = k;
        rs_pos  = at_pos;
        rs_line = at_line;
        rs_col  = at_col;
    endtask

    task automatic close_run();
        if (cls != CLS_NONE)
            push_tok(kind_t'(cls), rs_pos, rs_line, rs_col, at_pos - rs_pos, ERR_NONE, 1'b0);
        cls         = CLS_NONE;
        par_pending = 1'b0;
    endtask

    task automatic halt(input err_t code);
        stopped     = 1'b1;
        stop_code   = code;
        cls         = CLS_NONE;
        par_pending = 1'b0;
        push_tok(KIND_NEWLINE, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, code, 1'b1);
    endtask

    task automatic lex_step(input logic [7:0] c, input logic present, input logic fin);
        int  base;
        int  k;
        bit  taken;
        if (stopped)
        begin
            push_tok(KIND_NEWLINE, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, stop_code, 1'b1);
            return;
        end
        base = token_q.size();
        if (present)
        begin
            taken = 1'b0;
            if (cls == CLS_PARAM && par_pending)
            begin
                par_pending = 1'b0;
                if (digit_ch(c))
                begin
                    halt(ERR_PARAM_DIGIT);
                    return;
                end
            end
            if (cls != CLS_NONE)
            begin
                if (stays_in_run(cls, c))
                    taken = 1'b1;
                else
                    close_run();
            end
            if (!taken)
            begin
                k = punct_index(c);
                if (c == CH_NL)
                    push_tok(KIND_NEWLINE, at_pos, at_line, at_col, POS_ONE, ERR_NONE, 1'b0);
                else if (blank_ch(c))
                    open_run(CLS_BLANK);
                else if (c == CH_AT)
                    open_run(CLS_KEYWORD);
                else if (letter_ch(c))
                    open_run(CLS_IDENT);
                else if (c == CH_DOLLAR)
                begin
                    open_run(CLS_PARAM);
                    par_pending = 1'b1;
                end
                else if (digit_ch(c))
                    open_run(CLS_NUMBER);
                else if (c == CH_NUL)
                begin
                    halt(ERR_ZERO_BYTE);
                    return;
                end
                else if (k >= 0)
                    push_tok(kind_t'(PUNCT_BASE + k), at_pos, at_line, at_col, POS_ONE,
                             ERR_NONE, 1'b0);
                else
                begin
                    halt(ERR_UNHANDLED);
                    return;
                end
            end
            if (c == CH_NL)
            begin
                at_line = bump(at_line);
                at_col  = POS_ONE;
            end
            else
                at_col = bump(at_col);
            at_pos = bump(at_pos);
        end
        if (fin)
        begin
            close_run();
            push_tok(KIND_END, POS_ZERO, POS_ZERO, POS_ZERO, POS_ONE, ERR_NONE, 1'b0);
            at_pos  = POS_ZERO;
            at_line = POS_ONE;
            at_col  = POS_ONE;
        end
        if (token_q.size() > base)
            token_q[token_q.size()-1].last = 1'b1;
    endtask

    task automatic add_item(input logic [7:0] ch, input logic present, input logic fin);
        item_t it;
        it.ch      = ch;
        it.present = present;
        it.fin     = fin;
        it.gap     = calm ? 0 : $urandom_range(0, 5);
        it.hold    = hold_next;
        hold_next  = 0;
        byte_q.push_back(it);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_item(s[i], 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r < 62)
            return 8'("0" + r - 52);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] lead_char();
        logic [7:0] c;
        c = word_char();
        return digit_ch(c) ? CH_UNDER : c;
    endfunction

    task automatic add_stream(input int ntok);
        logic [7:0] txt[$];
        int         t;
        int         k;
        int         i;
        int         n;
        bit         lone;
        bit         end_on_byte;
        lone = 0;
        for (t = 0; t < ntok; t++)
        begin
            // a lone '$' must not be followed by a digit
            k = lone ? $urandom_range(0, 2) : $urandom_range(0, 8);
            lone = 0;
            case (k)
                0: txt.push_back(CH_NL);
                1:
                begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        txt.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                end
                2: txt.push_back(punct_set[$urandom_range(0, PUNCT_NUM - 1)]);
                3:
                begin
                    n = $urandom_range(32, 126);
                    txt.push_back((n == CH_DOLLAR) ? CH_AT : 8'(n));
                end
                4, 5:
                begin
                    txt.push_back(lead_char());
                    n = $urandom_range(0, 6);
                    for (i = 0; i < n; i++)
                        txt.push_back(word_char());
                end
                6:
                begin
                    txt.push_back(CH_AT);
                    n = $urandom_range(0, 5);
                    for (i = 0; i < n; i++)
                        txt.push_back(word_char());
                end
                7:
                begin
                    txt.push_back(CH_DOLLAR);
                    if ($urandom_range(0, 3) == 0)
                        lone = 1;
                    else
                    begin
                        txt.push_back(lead_char());
                        n = $urandom_range(0, 4);
                        for (i = 0; i < n; i++)
                            txt.push_back(word_char());
                    end
                end
                default:
                begin
                    n = $urandom_range(1, 5);
                    for (i = 0; i < n; i++)
                        txt.push_back(8'("0" + $urandom_range(0, 9)));
                end
            endcase
        end
        end_on_byte = $urandom_range(0, 1);
        for (i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_item(txt[i], 1'b1, end_on_byte && (i == txt.size() - 1));
        end
        if (!end_on_byte)
            add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
            tx_gap   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tx_gap != 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end
            else if (byte_q.size() != 0 &&
                     (!byte_q[0].hold || (!s_tvalid && token_q.size() == 0)))
            begin
                nxt = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.ch;
                s_tuser  <= nxt.present;
                s_tlast  <= nxt.fin;
                tx_gap   <= nxt.gap;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
            rx_count <= 0;
            choke    <= 0;
            choked   <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_count <= rx_count + 1;
            if (choke != 0)
            begin
                m_tready <= 1'b0;
                choke    <= choke - 1;
            end
            else if (!choked && rx_count >= 40)
            begin
                m_tready <= 1'b0;
                choke    <= 80;
                choked   <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                rx_draw = rx_calm ? 0 : $urandom_range(0, 5);
                m_tready <= (rx_draw == 0);
                rx_wait  <= rx_draw;
            end
            else if (!m_tready)
            begin
                if (rx_wait != 0)
                    rx_wait <= rx_wait - 1;
                else
                    m_tready <= 1'b1;
            end
        end
    end

    // monitor: predict on each accepted byte beat, check each token beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                lex_step(s_tdata, s_tuser[0], s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser[KIND_WIDTH-1:0];
                got.err  = err_t'(m_tuser[KIND_WIDTH+1:KIND_WIDTH]);
                got.pos  = m_tdata[P-1:0];
                got.line = m_tdata[2*P-1:P];
                got.col  = m_tdata[3*P-1:2*P];
                got.len  = m_tdata[4*P-1:3*P];
                got.last = m_tlast;
                if (token_q.size() == 0)
                    report($sformatf("unexpected token beat kind %0d err %0d",
                                     got.kind, got.err));
                else
                begin
                    want = token_q.pop_front();
                    if (got !== want)
                        report($sformatf({"got kind %0d pos %0d line %0d col %0d len %0d",
                                          " err %0d last %0d, want %0d %0d %0d %0d %0d %0d %0d"},
                                         got.kind, got.pos, got.line, got.col, got.len,
                                         got.err, got.last, want.kind, want.pos, want.line,
                                         want.col, want.len, want.err, want.last));
                end
            end
        end
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        cls         = CLS_NONE;
        rs_pos      = POS_ZERO;
        rs_line     = POS_ZERO;
        rs_col      = POS_ZERO;
        at_pos      = POS_ZERO;
        at_line     = POS_ONE;
        at_col      = POS_ONE;
        par_pending = 1'b0;
        stopped     = 1'b0;
        stop_code   = ERR_NONE;

        // directed
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        add_text("Zz_09 \t12;@w9 $q_~ x");
        add_item(CH_NL, 1'b1, 1'b1);
        add_item(CH_DOLLAR, 1'b1, 1'b1);
        add_item(CH_AT, 1'b1, 1'b1);

        // random streams
        stream_idx = 0;
        while (byte_q.size() < 350)
        begin
            calm = (stream_idx >= 4 && stream_idx < 7);
            if (stream_idx == 9)
                hold_next = 1;
            add_stream($urandom_range(3, 20));
            stream_idx++;
        end
        calm = 0;

        // one sticky error, then beats that only echo it
        hold_next = 1;
        add_text("ok ");
        err_pick = $urandom_range(1, 3);
        if (err_pick == 1)
            add_item(CH_NUL, 1'b1, 1'b0);
        else if (err_pick == 2)
        begin
            case ($urandom_range(0, 2))
                0:       add_item(8'($urandom_range(128, 255)), 1'b1, 1'b0);
                1:       add_item(8'h0D, 1'b1, 1'b0);
                default: add_item(8'($urandom_range(1, 8)), 1'b1, 1'b0);
            endcase
        end
        else
        begin
            add_item(CH_DOLLAR, 1'b1, 1'b0);
            add_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
        end
        for (j = 0; j < 8; j++)
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (byte_q.size() != 0 || s_tvalid);
        guard = 0;
        while (token_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (token_q.size() != 0)
            report($sformatf("%0d token beats never arrived", token_q.size()));

        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
